>>> hdl/kfci_pkg.sv
// Shared types, constants and helpers for the keyframe curve interpolator.
package kfci_pkg;

  localparam int WT_W  = 16;              // weight bits (Q0.16)
  localparam int NUM_W = 33;              // time difference bits
  localparam int HW    = 40;              // polynomial accumulator bits
  localparam int PW    = HW + WT_W + 1;   // product bits

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_INS_PUT,
    ST_EV_RD,
    ST_EV_CHK,
    ST_EV_P3,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PREP,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } kfci_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] hi_lim;
    logic signed [PW-1:0] lo_lim;
    hi_lim = PW'(32'sh7fff_ffff);
    lo_lim = -PW'(32'sh7fff_ffff) - PW'(1);
    if (x > hi_lim) begin
      return 32'sh7fff_ffff;
    end else if (x < lo_lim) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

>>> hdl/kfci_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kfci_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/kfci_div.sv
// Restoring divider for the interpolation weight, one quotient bit per cycle.
module kfci_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [kfci_pkg::NUM_W-1:0] num,
  input  logic [kfci_pkg::NUM_W-1:0] den,
  output logic                       done,
  output logic [kfci_pkg::WT_W-1:0]  quot
);
  import kfci_pkg::*;

  localparam int CNT_W = $clog2(WT_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W:0]   rem;
  logic [NUM_W-1:0] dsr;
  logic [NUM_W:0]   rem_sh;
  logic             fits;

  // num < den always, so the shifted remainder stays below twice the divisor
  assign rem_sh = {rem[NUM_W-1:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(WT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num};
      dsr  <= den;
      cnt  <= '0;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
      quot <= {quot[WT_W-2:0], fits};
      cnt  <= cnt + CNT_W'(1);
    end
  end

endmodule

>>> hdl/keyframe_curve_interpolator_unit.sv
// Keyframe table with linear / Catmull-Rom curve evaluation.
// Insert: each key shifted up takes one RAM read and one write-back, then the new key is written.
// Evaluate: keys are scanned from the table start, then the weight is divided and the
//   multiply-add runs; there is no division on an exact match or outside the key range.
// One item in flight; the output register holds while the next item is taken.
// Synchronous reset empties the table (count to zero) and selects linear mode.
module keyframe_curve_interpolator_unit #(
  parameter int MAX_KEYS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] sample_time,
  input  logic signed [31:0] key_value_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] curve_value,
  output logic               status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import kfci_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  kfci_state_t state, state_next;

  logic [CW-1:0] count, idx, idx_inc;
  logic          mode;
  logic signed [31:0] t_r, kv_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;
  logic signed [31:0] rd_time, rd_val;

  logic signed [31:0] prev_t, prev_v, prev2_v;
  logic signed [31:0] t1, t2, v1, v2, p0, p3;
  logic signed [31:0] res_val;
  logic               res_st;
  logic signed [31:0] out_value;
  logic               out_status;

  logic              div_start, div_done;
  logic [WT_W-1:0]   div_q, w;
  logic [NUM_W-1:0]  div_num, div_den;

  logic signed [HW-1:0] h, a_r, b_r, a_c, b_c, c_c, addend;
  logic signed [PW-1:0] prod, lin_sum, hn;
  logic [1:0]           step;
  logic                 found, last_key, shift_up;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign curve_value = out_value;
  assign status      = out_status;

  assign rd_time  = ram_rdata[63:32];
  assign rd_val   = ram_rdata[31:0];
  assign idx_inc  = idx + CW'(1);
  assign found    = rd_time >= t_r;
  assign last_key = idx == count - CW'(1);
  assign shift_up = rd_time > t_r;

  assign div_num = NUM_W'(t_r) - NUM_W'(t1);
  assign div_den = NUM_W'(t2) - NUM_W'(t1);

  assign a_c = HW'(v2) - HW'(p0);
  assign b_c = (HW'(p0) <<< 1) - 5 * HW'(v1) + (HW'(v2) <<< 2) - HW'(p3);
  assign c_c = -HW'(p0) + 3 * HW'(v1) - 3 * HW'(v2) + HW'(p3);

  always_comb begin
    case (step)
      2'd0:    addend = b_r;
      2'd1:    addend = a_r;
      default: addend = HW'(v1) <<< 1;
    endcase
  end

  assign lin_sum = prod + (PW'(v1) <<< 16) + PW'(32768);
  assign hn      = (prod >>> 16) + PW'(addend);

  kfci_ram #(.WIDTH(64), .DEPTH(MAX_KEYS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kfci_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = idx[AW-1:0];
    ram_wdata  = {t_r, kv_r};
    ram_raddr  = idx[AW-1:0];
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_SAMPLE) begin
            state_next = (count == '0) ? ST_DONE : ST_EV_RD;
          end else if (count == CW'(MAX_KEYS)) begin
            state_next = ST_DONE;
          end else if (count == '0) begin
            state_next = ST_INS_PUT;
          end else begin
            state_next = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: state_next = ST_INS_CHK;
      ST_INS_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = idx_inc[AW-1:0];
        if (shift_up) begin
          ram_wdata  = ram_rdata;
          state_next = (idx == '0) ? ST_INS_PUT : ST_INS_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_INS_PUT: begin
        ram_we     = 1'b1;
        state_next = ST_DONE;
      end
      ST_EV_RD: state_next = ST_EV_CHK;
      ST_EV_CHK: begin
        // fetch the key after the upper neighbor for the cubic
        ram_raddr = idx_inc[AW-1:0];
        if (found) begin
          if (rd_time == t_r || idx == '0) begin
            state_next = ST_DONE;
          end else if (mode && idx_inc != count) begin
            state_next = ST_EV_P3;
          end else begin
            state_next = ST_DIV_GO;
          end
        end else begin
          state_next = last_key ? ST_DONE : ST_EV_RD;
        end
      end
      ST_EV_P3: state_next = ST_DIV_GO;
      ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = mode ? ST_PREP : ST_MUL;
        end
      end
      ST_PREP: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = (!mode || step == 2'd2) ? ST_DONE : ST_MUL;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      mode      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode <= cfg_data;
      end
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if ((state == ST_INS_CHK && !shift_up) || state == ST_INS_PUT) begin
        count <= count + CW'(1);
      end
    end
  end

  // hand the finished item to the output register once it is free
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_value  <= res_val;
      out_status <= res_st;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        t_r     <= sample_time;
        kv_r    <= key_value_in;
        res_val <= '0;
        res_st  <= cmd == CMD_INSERT && count == CW'(MAX_KEYS);
        idx     <= (cmd == CMD_SAMPLE || count == '0) ? '0 : count - CW'(1);
      end
      ST_INS_CHK: begin
        if (shift_up && idx != '0) begin
          idx <= idx - CW'(1);
        end
      end
      ST_EV_CHK: begin
        if (found) begin
          if (rd_time == t_r || idx == '0) begin
            res_val <= rd_val;
          end
          t1 <= prev_t;
          v1 <= prev_v;
          t2 <= rd_time;
          v2 <= rd_val;
          p3 <= rd_val;
          p0 <= (idx >= CW'(2)) ? prev2_v : prev_v;
        end else begin
          if (last_key) begin
            res_val <= rd_val;
          end
          prev2_v <= prev_v;
          prev_v  <= rd_val;
          prev_t  <= rd_time;
          idx     <= idx_inc;
        end
      end
      ST_EV_P3: p3 <= rd_val;
      ST_DIV_WAIT: begin
        w    <= div_q;
        h    <= HW'(v2) - HW'(v1);
        step <= 2'd0;
      end
      ST_PREP: begin
        h   <= c_c;
        a_r <= a_c;
        b_r <= b_c;
      end
      ST_MUL: prod <= h * $signed({1'b0, w});
      ST_ADD: begin
        if (!mode) begin
          res_val <= sat32(lin_sum >>> 16);
        end else if (step == 2'd2) begin
          res_val <= sat32((hn + PW'(1)) >>> 1);
        end else begin
          h    <= hn[HW-1:0];
          step <= step + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/kfci_chk.sv
// Port-level checker for the keyframe curve interpolator, bound to the top level.
module kfci_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] curve_value,
  input logic               status
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(curve_value) && $stable(status))
    else $error("stalled result changed");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> curve_value == 32'sd0)
    else $error("dropped insert carries a nonzero value");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // one item at a time: an accepted item blocks the input next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

endmodule

bind keyframe_curve_interpolator_unit kfci_chk u_kfci_chk (.*);

>>> sim/keyframe_curve_checker.sv
// Checker for the keyframe curve interpolator: tracks the key table, predicts and compares.
`timescale 1ns / 100ps
module keyframe_curve_checker #(
  parameter int MAX_KEYS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] sample_time,
  input  logic signed [31:0] key_value_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] curve_value,
  input  logic               status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_data,
  output int                 mismatches,
  output int                 pending
);
  import kfci_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    logic               full;
  } curve_result_t;

  logic signed [31:0] tbl_time [MAX_KEYS];
  logic signed [31:0] tbl_val [MAX_KEYS];
  int                 tbl_count;
  logic               cubic_mode;
  curve_result_t      expected_q [$];

  function automatic longint floor16(longint x);
    return x >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] sample_curve(longint t);
    int     lo;
    int     hi;
    longint t1;
    longint w;
    longint v1;
    longint v2;
    longint p0;
    longint p3;
    longint h;
    lo = 0;
    if (tbl_count == 0) return 0;
    if (t < tbl_time[0]) return tbl_val[0];
    if (t > tbl_time[tbl_count-1]) return tbl_val[tbl_count-1];
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_time[i] == t) return tbl_val[i];
      if (t > tbl_time[i]) lo = i;
    end
    hi = lo + 1;
    t1 = tbl_time[lo];
    w = ((t - t1) <<< 16) / (longint'(tbl_time[hi]) - t1);
    v1 = tbl_val[lo];
    v2 = tbl_val[hi];
    if (!cubic_mode) return clamp32(floor16(v1 * (65536 - w) + v2 * w + 32768));
    p0 = (lo > 0) ? longint'(tbl_val[lo-1]) : v1;
    p3 = (hi + 1 < tbl_count) ? longint'(tbl_val[hi+1]) : v2;
    h = -p0 + 3 * v1 - 3 * v2 + p3;
    h = floor16(h * w) + (2 * p0 - 5 * v1 + 4 * v2 - p3);
    h = floor16(h * w) + (v2 - p0);
    h = floor16(h * w) + 2 * v1;
    return clamp32((h + 1) >>> 1);
  endfunction

  always @(posedge clk) begin
    curve_result_t exp_r;
    curve_result_t got;
    int            pos;
    if (rst) begin
      tbl_count <= 0;
      cubic_mode <= 1'b0;
      expected_q.delete();
      mismatches <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cubic_mode <= cfg_data;
      if (in_valid && !in_stall) begin
        exp_r = '0;
        if (cmd == CMD_INSERT) begin
          if (tbl_count >= MAX_KEYS) begin
            exp_r.full = 1'b1;
          end else begin
            pos = tbl_count;
            while (pos > 0 && tbl_time[pos-1] > sample_time) begin
              tbl_time[pos] = tbl_time[pos-1];
              tbl_val[pos] = tbl_val[pos-1];
              pos--;
            end
            tbl_time[pos] = sample_time;
            tbl_val[pos] = key_value_in;
            tbl_count <= tbl_count + 1;
          end
        end else begin
          exp_r.value = sample_curve(sample_time);
        end
        expected_q.push_back(exp_r);
      end
      if (out_valid && !out_stall) begin
        got.value = curve_value;
        got.full = status;
        if (expected_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected item: value %h status %b", curve_value, status);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            if (mismatches < 10)
              $display("mismatch: expected value %h status %b, got value %h status %b",
                       exp_r.value, exp_r.full, got.value, got.full);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

>>> sim/keyframe_curve_interpolator_unit_tb.sv
// Testbench top: drives keyframe inserts and curve samples, gives the verdict.
`timescale 1ns / 100ps
module keyframe_curve_interpolator_unit_tb;
  import kfci_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               cmd = CMD_INSERT;
  logic signed [31:0] sample_time = '0;
  logic signed [31:0] key_value_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] curve_value;
  logic               status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;
  int                 mismatches;
  int                 pending;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 hold_cycles = 0;
  logic               hold_req = 1'b0;
  logic               hold_taken = 1'b0;
  logic signed [31:0] key_times_used [$];

  always #5 clk = ~clk;

  keyframe_curve_interpolator_unit DUT (.*);

  keyframe_curve_checker checker_i (.*);

  // receiver stall: random, or a long counted hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= 3000;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_item(input logic c, input logic signed [31:0] t,
                           input logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    sample_time <= t;
    key_value_in <= v;
    if (c == CMD_INSERT) key_times_used.push_back(t);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_time();
    if (key_times_used.size() > 0 && $urandom_range(3) == 0)
      return key_times_used[$urandom_range(key_times_used.size() - 1)];
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0000;
      default: return $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  // one phase: insert keys, some followed by a sample, then sample
  task automatic run_table(input int nkeys, input int nsamples);
    key_times_used.delete();
    for (int i = 0; i < nkeys; i++) begin
      send_item(CMD_INSERT, rand_time(), rand_val());
      if ($urandom_range(3) == 0) send_item(CMD_SAMPLE, rand_time(), $urandom);
    end
    for (int i = 0; i < nsamples; i++) send_item(CMD_SAMPLE, rand_time(), $urandom);
  endtask

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty table, extremes, exact match, ties, full table
    send_item(CMD_SAMPLE, 32'sh0, 32'sh0);
    send_item(CMD_INSERT, 32'sh0001_0000, 32'sh7fff_ffff);
    send_item(CMD_INSERT, 32'sh0003_0000, 32'sh8000_0000);
    send_item(CMD_INSERT, 32'sh0003_0000, 32'sh0000_1000);
    send_item(CMD_INSERT, 32'sh8000_0000, 32'sh0);
    send_item(CMD_INSERT, 32'sh7fff_ffff, 32'shffff_ffff);
    send_item(CMD_SAMPLE, 32'sh0003_0000, 32'sh0);
    send_item(CMD_SAMPLE, 32'sh0002_0000, 32'shffff_ffff);
    send_item(CMD_SAMPLE, 32'sh8000_0001, 32'sh0);
    send_item(CMD_SAMPLE, 32'sh7fff_fffe, 32'sh0);
    drain();
    set_mode(1'b1);
    send_item(CMD_SAMPLE, 32'sh0002_0000, 32'sh0);
    send_item(CMD_SAMPLE, 32'sh0000_8000, 32'sh0);
    send_item(CMD_SAMPLE, 32'sh0004_0000, 32'sh0);
    for (int i = 0; i < 60; i++) send_item(CMD_INSERT, 32'sh0005_0000, i);
    send_item(CMD_SAMPLE, 32'sh0004_ffff, 32'sh0);
    // hold the receiver long while the sender keeps offering items
    hold_req <= 1'b1;
    for (int i = 0; i < 8; i++) send_item(CMD_SAMPLE, rand_time(), 32'sh0);
    drain();

    // random phases; a fresh table comes from a full one only via reset, so
    // the phases insert no keys and only sample the full table from above
    send_idle_pct = 12;
    recv_idle_pct = 55;
    run_table(0, 150);
    drain();
    set_mode(1'b0);
    run_table(0, 150);
    drain();
    send_idle_pct = 55;
    recv_idle_pct = 12;
    set_mode(1'b1);
    run_table(0, 150);
    drain();
    set_mode(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_table(0, 150);
    drain();
    set_mode(1'b1);
    run_table(0, 200);
    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/kfci_pkg.sv
hdl/kfci_ram.sv
hdl/kfci_div.sv
hdl/keyframe_curve_interpolator_unit.sv
hdl/kfci_chk.sv
sim/keyframe_curve_checker.sv
sim/keyframe_curve_interpolator_unit_tb.sv
